>>> rtl/tgt_pkg.sv
`default_nettype none
package tgt_pkg;

	localparam int SPEED_WINDOW_DEF = 10;
	localparam int BURN_IN_CAP_DEF  = 100;

	localparam int GAIN_W     = 32;
	localparam int STEP_W     = 31;
	localparam int LEN_W      = 12;
	localparam int SAMPLE_W   = 16;
	localparam int SQSUM_W    = 42;
	localparam int NGAINS     = 3;

	localparam logic [31:0]          PENALTY   = 32'hFFFF_FFFF;
	localparam logic [STEP_W-1:0]    STEP_MAX  = 31'h7FFF_FFFF;
	localparam logic signed [15:0]   CTE_LIMIT = 16'sd6656;
	localparam int WIN_MIN_FILL  = 5;
	localparam int SPD_LIM_NUM   = 100;
	localparam int SPD_LIM_DEN   = 512;
	localparam int GROW_NUM      = 11;
	localparam int SHRINK_NUM    = 9;
	localparam int SCALE_DEN     = 10;
	localparam int SCALE_ROUND   = 5;

	localparam logic [LEN_W-1:0]  TRIAL_LENGTH_RST = 12'd650;
	localparam logic [STEP_W-1:0] TOLERANCE_RST    = 31'd13107;
	localparam logic [STEP_W-1:0] START_STEP_RST   = 31'd65536;

	typedef enum logic [2:0] {
		REG_TRIAL_LENGTH = 3'd0,
		REG_TOLERANCE    = 3'd1,
		REG_START_GAIN_A = 3'd2,
		REG_START_GAIN_B = 3'd3,
		REG_START_GAIN_C = 3'd4,
		REG_START_STEP_A = 3'd5,
		REG_START_STEP_B = 3'd6,
		REG_START_STEP_C = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] cte_sample;
		logic signed [15:0] speed_sample;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] trial_gain_a;
		logic signed [31:0] trial_gain_b;
		logic signed [31:0] trial_gain_c;
		logic signed [31:0] best_gain_a;
		logic signed [31:0] best_gain_b;
		logic signed [31:0] best_gain_c;
		logic [31:0]        best_score;
		logic               restart_trial;
		logic               tuning_done;
	} out_item_t;

	typedef struct packed {
		reg_idx_t    index;
		logic [31:0] value;
	} cfg_item_t;

	typedef enum logic [3:0] {
		OP_IDLE, OP_CAPTURE, OP_LOAD, OP_BURN, OP_SHIFT, OP_ABORT, OP_ACCUM,
		OP_MEAN, OP_MEAN_TAKE, OP_UPDATE, OP_STEP_TAKE, OP_FINISH, OP_ADVANCE,
		OP_ADD, OP_EMIT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic restart;
	} cmd_t;

	typedef struct packed {
		logic finished;
		logic burn_skip;
		logic abort;
		logic trial_full;
		logic upd_scale;
		logic div_done;
		logic adv_finish;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

>>> rtl/tgt_chan_if.sv
`default_nettype none
interface tgt_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/tgt_div.sv
`default_nettype none
module tgt_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [tgt_pkg::SQSUM_W-1:0] numer,
	input  wire logic [tgt_pkg::LEN_W-1:0]   denom,
	output logic                             busy,
	output logic                             done,
	output logic [tgt_pkg::SQSUM_W-1:0]      quot
);
	import tgt_pkg::*;

	localparam int CNT_W = $clog2(SQSUM_W + 1);

	logic [CNT_W-1:0]   cnt_q;
	logic [LEN_W:0]     rem_q;
	logic [SQSUM_W-1:0] quo_q;
	logic               busy_q;
	logic               done_q;
	logic [LEN_W:0]     trial;
	logic               fits;

	assign trial = {rem_q[LEN_W-1:0], quo_q[SQSUM_W-1]};
	assign fits  = trial >= {1'b0, denom};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SQSUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= numer;
		end else if (busy_q) begin
			rem_q <= fits ? trial - {1'b0, denom} : trial;
			quo_q <= {quo_q[SQSUM_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quo_q;
endmodule
`default_nettype wire

>>> rtl/tgt_dp.sv
`default_nettype none
module tgt_dp #(
	parameter int SPEED_WINDOW = tgt_pkg::SPEED_WINDOW_DEF,
	parameter int BURN_IN_CAP  = tgt_pkg::BURN_IN_CAP_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tgt_pkg::cmd_t      cmd,
	output tgt_pkg::stat_t          stat,
	input  wire tgt_pkg::in_item_t  in_data,
	input  wire logic               cfg_valid,
	input  wire tgt_pkg::cfg_item_t cfg_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output tgt_pkg::out_item_t      out_data
);
	import tgt_pkg::*;

	localparam int FILL_W  = $clog2(SPEED_WINDOW + 1);
	localparam int WSUM_W  = SAMPLE_W + $clog2(SPEED_WINDOW);
	localparam int CMP_W   = WSUM_W + 10;
	localparam int BURN_W  = $clog2(BURN_IN_CAP + 1);

	// floor(x / 10) == (x * TENTH_RECIP) >> 35 for any 32-bit x
	localparam logic [31:0] TENTH_RECIP = 32'hCCCC_CCCD;

	typedef enum logic [1:0] {PH_INIT, PH_PLUS, PH_MINUS} phase_t;

	function automatic logic signed [31:0] clamp32(input logic signed [33:0] v);
		if (v > 34'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -34'sd2147483648) return 32'sh8000_0000;
		return $signed(v[31:0]);
	endfunction

	// configuration
	logic [LEN_W-1:0]         tl_q;
	logic [STEP_W-1:0]        tol_q;
	logic signed [GAIN_W-1:0] sg_q [NGAINS];
	logic [STEP_W-1:0]        ss_q [NGAINS];

	// tuner state
	phase_t                   phase_q;
	logic                     loaded_q;
	logic                     fin_q;
	logic signed [GAIN_W-1:0] gain_q [NGAINS];
	logic signed [GAIN_W-1:0] best_q [NGAINS];
	logic [STEP_W-1:0]        step_q [NGAINS];
	logic [1:0]               gi_q;
	logic [BURN_W-1:0]        burn_q;
	logic [LEN_W-1:0]         cnt_q;
	logic [SQSUM_W-1:0]       sqs_q;
	logic [SAMPLE_W-1:0]      win_q [SPEED_WINDOW];
	logic [FILL_W-1:0]        fill_q;
	logic [WSUM_W-1:0]        wsum_q;
	logic [31:0]              score_q;
	logic [31:0]              est_q;
	logic signed [15:0]       cte_q;
	logic [SAMPLE_W-1:0]      mag_q;
	logic                     grow_q;
	logic                     out_valid_q;
	out_item_t                out_q;

	logic [LEN_W-1:0]         len;
	logic [LEN_W-1:0]         burn_half;
	logic [BURN_W:0]          burn_lim;
	logic signed [16:0]       spd_x;
	logic signed [GAIN_W-1:0] g_sel;
	logic [STEP_W-1:0]        s_sel;
	logic signed [33:0]       g_ext;
	logic signed [31:0]       g_plus;
	logic signed [31:0]       g_minus2;
	logic                     better;
	logic [31:0]              scale_base;
	logic [63:0]              scale_prod;
	logic [28:0]              scale_q10;
	logic [31:0]              grown;
	logic [STEP_W-1:0]        step_new;
	logic [32:0]              step_sum;
	logic signed [31:0]       cte_sq;
	logic                     win_low;
	logic                     div_start;
	logic [SQSUM_W-1:0]       div_numer;
	logic [LEN_W-1:0]         div_denom;
	logic                     div_busy;
	logic                     div_done;
	logic [SQSUM_W-1:0]       div_quot;

	assign len       = (tl_q == '0) ? LEN_W'(1) : tl_q;
	assign burn_half = len >> 1;
	assign burn_lim  = (burn_half > LEN_W'(BURN_IN_CAP)) ? (BURN_W+1)'(BURN_IN_CAP)
	                                                     : (BURN_W+1)'(burn_half);
	assign spd_x     = 17'(in_data.speed_sample);
	assign g_sel     = gain_q[gi_q];
	assign s_sel     = step_q[gi_q];
	assign g_ext     = 34'(g_sel);
	assign g_plus    = clamp32(g_ext + $signed({3'b000, s_sel}));
	assign g_minus2  = clamp32(g_ext - $signed({2'b00, s_sel, 1'b0}));
	assign better    = est_q < score_q;
	// x1.1 rounded is s + (s+5)/10, x0.9 rounded is s - (s+4)/10
	assign scale_base = grow_q ? 32'(s_sel) + 32'(SCALE_ROUND)
	                           : 32'(s_sel) + 32'(SCALE_ROUND - 1);
	assign scale_prod = 64'(scale_base) * 64'(TENTH_RECIP);
	assign scale_q10  = scale_prod[63:35];
	assign grown      = 32'(s_sel) + 32'(scale_q10);
	assign step_new   = grow_q ? ((grown > 32'(STEP_MAX)) ? STEP_MAX : grown[STEP_W-1:0])
	                           : s_sel - STEP_W'(scale_q10);
	assign step_sum  = 33'(step_q[0]) + 33'(step_q[1]) + 33'(step_q[2]);
	assign cte_sq    = cte_q * cte_q;
	assign win_low   = CMP_W'(wsum_q) * CMP_W'(SPD_LIM_NUM) < CMP_W'(fill_q) * CMP_W'(SPD_LIM_DEN);

	always_comb begin
		stat.finished   = fin_q;
		stat.burn_skip  = (BURN_W+1)'(burn_q) + 1'b1 < burn_lim;
		stat.abort      = (fill_q > FILL_W'(WIN_MIN_FILL) && win_low) ||
		                  cte_q > CTE_LIMIT || cte_q < -CTE_LIMIT;
		stat.trial_full = cnt_q >= len;
		stat.upd_scale  = (phase_q == PH_PLUS && better) || phase_q == PH_MINUS;
		stat.div_done   = div_done;
		stat.adv_finish = gi_q == 2'd2 && step_sum < 33'(tol_q);
		stat.out_free   = !out_valid_q || out_ready;
	end

	assign div_start = cmd.op == OP_MEAN;
	assign div_numer = sqs_q;
	assign div_denom = cnt_q;

	tgt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_numer),
		.denom  (div_denom),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tl_q  <= TRIAL_LENGTH_RST;
			tol_q <= TOLERANCE_RST;
			for (int i = 0; i < NGAINS; i++) begin
				sg_q[i] <= '0;
				ss_q[i] <= START_STEP_RST;
			end
		end else if (cfg_valid) begin
			unique case (cfg_data.index)
				REG_TRIAL_LENGTH: tl_q    <= cfg_data.value[LEN_W-1:0];
				REG_TOLERANCE:    tol_q   <= cfg_data.value[STEP_W-1:0];
				REG_START_GAIN_A: sg_q[0] <= $signed(cfg_data.value);
				REG_START_GAIN_B: sg_q[1] <= $signed(cfg_data.value);
				REG_START_GAIN_C: sg_q[2] <= $signed(cfg_data.value);
				REG_START_STEP_A: ss_q[0] <= cfg_data.value[STEP_W-1:0];
				REG_START_STEP_B: ss_q[1] <= cfg_data.value[STEP_W-1:0];
				REG_START_STEP_C: ss_q[2] <= cfg_data.value[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_CAPTURE) begin
			cte_q <= in_data.cte_sample;
			mag_q <= spd_x[16] ? 16'(-spd_x) : 16'(spd_x);
		end
		if (cmd.op == OP_SHIFT) begin
			win_q[0] <= mag_q;
			for (int i = 1; i < SPEED_WINDOW; i++) win_q[i] <= win_q[i-1];
		end
		if (cmd.op == OP_ABORT) est_q <= PENALTY;
		if (cmd.op == OP_MEAN_TAKE) est_q <= div_quot[31:0];
		if (cmd.op == OP_UPDATE) grow_q <= !(phase_q == PH_MINUS && !better);
		if (cmd.op == OP_EMIT) begin
			out_q.trial_gain_a  <= gain_q[0];
			out_q.trial_gain_b  <= gain_q[1];
			out_q.trial_gain_c  <= gain_q[2];
			out_q.best_gain_a   <= best_q[0];
			out_q.best_gain_b   <= best_q[1];
			out_q.best_gain_c   <= best_q[2];
			out_q.best_score    <= score_q;
			out_q.restart_trial <= cmd.restart;
			out_q.tuning_done   <= fin_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_INIT;
			loaded_q    <= 1'b0;
			fin_q       <= 1'b0;
			gi_q        <= '0;
			burn_q      <= '0;
			cnt_q       <= '0;
			sqs_q       <= '0;
			fill_q      <= '0;
			wsum_q      <= '0;
			score_q     <= PENALTY;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NGAINS; i++) begin
				gain_q[i] <= '0;
				best_q[i] <= '0;
				step_q[i] <= '0;
			end
		end else begin
			if (cmd.op == OP_EMIT) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (cmd.op)
				OP_LOAD: if (!loaded_q) begin
					for (int i = 0; i < NGAINS; i++) begin
						gain_q[i] <= sg_q[i];
						best_q[i] <= sg_q[i];
						step_q[i] <= ss_q[i];
					end
					score_q  <= PENALTY;
					phase_q  <= PH_INIT;
					gi_q     <= '0;
					burn_q   <= '0;
					cnt_q    <= '0;
					sqs_q    <= '0;
					fill_q   <= '0;
					wsum_q   <= '0;
					loaded_q <= 1'b1;
				end
				OP_BURN: burn_q <= burn_q + 1'b1;
				OP_SHIFT: begin
					// running window sum: add newest, and once full drop the one shifted out
					if (fill_q == FILL_W'(SPEED_WINDOW)) begin
						wsum_q <= wsum_q + WSUM_W'(mag_q) - WSUM_W'(win_q[SPEED_WINDOW-1]);
					end else begin
						wsum_q <= wsum_q + WSUM_W'(mag_q);
						fill_q <= fill_q + 1'b1;
					end
				end
				OP_ACCUM: begin
					sqs_q <= sqs_q + SQSUM_W'(unsigned'(cte_sq));
					cnt_q <= cnt_q + 1'b1;
				end
				OP_UPDATE: begin
					case (phase_q)
						PH_PLUS: if (better) begin
							score_q <= est_q;
							for (int i = 0; i < NGAINS; i++) best_q[i] <= gain_q[i];
						end else begin
							gain_q[gi_q] <= g_minus2;
							phase_q      <= PH_MINUS;
						end
						PH_MINUS: if (better) begin
							score_q <= est_q;
							for (int i = 0; i < NGAINS; i++) best_q[i] <= gain_q[i];
						end else begin
							gain_q[gi_q] <= g_plus;
						end
						default: begin
							score_q   <= est_q;
							gi_q      <= '0;
							gain_q[0] <= clamp32(34'(gain_q[0]) + $signed({3'b000, step_q[0]}));
							phase_q   <= PH_PLUS;
						end
					endcase
					if (!stat.upd_scale) begin
						burn_q <= '0;
						cnt_q  <= '0;
						sqs_q  <= '0;
						fill_q <= '0;
						wsum_q <= '0;
					end
				end
				OP_STEP_TAKE: step_q[gi_q] <= step_new;
				OP_FINISH:  fin_q <= 1'b1;
				OP_ADVANCE: gi_q <= (gi_q == 2'd2) ? 2'd0 : gi_q + 1'b1;
				OP_ADD: begin
					gain_q[gi_q] <= g_plus;
					phase_q      <= PH_PLUS;
					burn_q       <= '0;
					cnt_q        <= '0;
					sqs_q        <= '0;
					fill_q       <= '0;
					wsum_q       <= '0;
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_div_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(SPEED_WINDOW))
		else $error("window fill past depth");
	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		gi_q != 2'd3)
		else $error("gain index out of range");
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |=> fin_q)
		else $error("finished flag dropped");
`endif
endmodule
`default_nettype wire

>>> rtl/tgt_ctrl.sv
`default_nettype none
module tgt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire tgt_pkg::stat_t stat,
	output tgt_pkg::cmd_t       cmd
);
	import tgt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_BURN, S_CHECK, S_TEST, S_MDIV, S_UPD, S_SDIV, S_ADV,
		S_ADD, S_EMIT
	} state_t;

	state_t state_q, state_d;
	logic   restart_q, restart_d;

	always_comb begin
		state_d     = state_q;
		restart_d   = restart_q;
		cmd.op      = OP_IDLE;
		cmd.restart = restart_q;
		in_ready    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_CAPTURE;
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				restart_d = 1'b0;
				if (stat.finished) begin
					state_d = S_EMIT;
				end else begin
					cmd.op  = OP_LOAD;
					state_d = S_BURN;
				end
			end
			S_BURN: begin
				if (stat.burn_skip) begin
					cmd.op  = OP_BURN;
					state_d = S_EMIT;
				end else begin
					cmd.op  = OP_SHIFT;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.abort) begin
					cmd.op  = OP_ABORT;
					state_d = S_UPD;
				end else begin
					cmd.op  = OP_ACCUM;
					state_d = S_TEST;
				end
			end
			S_TEST: begin
				if (stat.trial_full) begin
					cmd.op  = OP_MEAN;
					state_d = S_MDIV;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_MDIV: if (stat.div_done) begin
				cmd.op  = OP_MEAN_TAKE;
				state_d = S_UPD;
			end
			S_UPD: begin
				cmd.op    = OP_UPDATE;
				restart_d = 1'b1;
				state_d   = stat.upd_scale ? S_SDIV : S_EMIT;
			end
			S_SDIV: begin
				cmd.op  = OP_STEP_TAKE;
				state_d = S_ADV;
			end
			S_ADV: begin
				if (stat.adv_finish) begin
					cmd.op  = OP_FINISH;
					state_d = S_EMIT;
				end else begin
					cmd.op  = OP_ADVANCE;
					state_d = S_ADD;
				end
			end
			S_ADD: begin
				cmd.op  = OP_ADD;
				state_d = S_EMIT;
			end
			S_EMIT: if (stat.out_free) begin
				cmd.op  = OP_EMIT;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			restart_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			restart_q <= restart_d;
		end
	end
endmodule
`default_nettype wire

>>> rtl/twiddle_gain_tuner.sv
`default_nettype none
// Twiddle gain tuner. Each transfer on sample carries one error and one speed
// sample; each yields exactly one transfer on result with the gains to use now,
// the best gains and score so far, and the restart and done flags. A sample
// that completes a trial runs the mean squared error through a 42-step
// radix-2 divider, while the x1.1 / x0.9 step scaling is a combinational
// reciprocal multiply. Handling of a sample stalls before its result is
// emitted while the result register still waits on result.ready. A sample is
// taken while the previous result still waits in the output register.
// Configuration writes are always accepted; start gains and start steps are
// latched on the first sample after reset, while trial_length and tolerance
// take effect at once.
module twiddle_gain_tuner #(
	parameter int SPEED_WINDOW = tgt_pkg::SPEED_WINDOW_DEF,
	parameter int BURN_IN_CAP  = tgt_pkg::BURN_IN_CAP_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	tgt_chan_if.sink   sample,
	tgt_chan_if.source result,
	tgt_chan_if.sink   cfg
);
	import tgt_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg.ready = 1'b1;

	tgt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tgt_dp #(
		.SPEED_WINDOW (SPEED_WINDOW),
		.BURN_IN_CAP  (BURN_IN_CAP)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (sample.data),
		.cfg_valid (cfg.valid),
		.cfg_data  (cfg.data),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (result.data)
	);
endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
module testbench;
	import tgt_pkg::*;

	typedef enum logic [1:0] {TUNE_INIT, TUNE_PLUS, TUNE_MINUS} tune_phase_t;

	localparam int WIN_DEPTH = SPEED_WINDOW_DEF;
	localparam int LIMIT_CYCLES = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b1;

	tgt_chan_if #(.T(in_item_t))  sample ();
	tgt_chan_if #(.T(out_item_t)) result ();
	tgt_chan_if #(.T(cfg_item_t)) cfg ();

	twiddle_gain_tuner i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.result (result),
		.cfg    (cfg)
	);

	// register copies
	logic [LEN_W-1:0]  len_reg;
	logic [STEP_W-1:0] tol_reg;
	longint            start_gain_reg [NGAINS];
	longint unsigned   start_step_reg [NGAINS];

	// tuner state
	tune_phase_t       tune_phase;
	bit                loaded;
	longint            gains_now [NGAINS];
	longint unsigned   steps [NGAINS];
	longint            gains_best [NGAINS];
	int unsigned       gain_idx;
	int unsigned       burn_cnt;
	int unsigned       trial_cnt;
	longint unsigned   sq_sum;
	longint unsigned   speed_win [WIN_DEPTH];
	int unsigned       win_fill;
	logic [31:0]       score_best;
	bit                tuned;
	int unsigned       live_items;

	in_item_t  pend_q [$];
	out_item_t gains_q [$];
	bit        failed = 1'b0;
	bit        quiet = 1'b0;
	bit        press_req = 1'b0;
	bit        press_taken;
	int        send_gap, rcv_gap, hold_left;
	int unsigned cycles = 0;

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned scale_step(longint unsigned s, int unsigned num);
		longint unsigned t;
		t = (s * num + SCALE_ROUND) / SCALE_DEN;
		return (t > STEP_MAX) ? longint'(STEP_MAX) : t;
	endfunction

	function automatic out_item_t snapshot(bit restart);
		out_item_t o;
		o.trial_gain_a  = gains_now[0][31:0];
		o.trial_gain_b  = gains_now[1][31:0];
		o.trial_gain_c  = gains_now[2][31:0];
		o.best_gain_a   = gains_best[0][31:0];
		o.best_gain_b   = gains_best[1][31:0];
		o.best_gain_c   = gains_best[2][31:0];
		o.best_score    = score_best;
		o.restart_trial = restart;
		o.tuning_done   = tuned;
		return o;
	endfunction

	function automatic void clear_trial();
		burn_cnt = 0;
		trial_cnt = 0;
		sq_sum = 0;
		win_fill = 0;
	endfunction

	function automatic bit next_gain();
		gain_idx++;
		if (gain_idx >= NGAINS) begin
			if (steps[0] + steps[1] + steps[2] < tol_reg) begin
				tuned = 1'b1;
				return 1'b1;
			end
			gain_idx = 0;
		end
		return 1'b0;
	endfunction

	function automatic void reset_tuner();
		len_reg = TRIAL_LENGTH_RST;
		tol_reg = TOLERANCE_RST;
		for (int i = 0; i < NGAINS; i++) begin
			start_gain_reg[i] = 0;
			start_step_reg[i] = START_STEP_RST;
			gains_now[i] = 0;
			steps[i] = 0;
			gains_best[i] = 0;
		end
		tune_phase = TUNE_INIT;
		loaded = 1'b0;
		gain_idx = 0;
		clear_trial();
		score_best = PENALTY;
		tuned = 1'b0;
		live_items = 0;
	endfunction

	function automatic out_item_t tune_step(in_item_t it);
		longint          cte, spd;
		longint unsigned mag, wsum, est;
		int unsigned     len, burn, gi;
		bit              ended;
		cte = it.cte_sample;
		spd = it.speed_sample;
		mag = (spd < 0) ? -spd : spd;
		len = (len_reg == 0) ? 1 : len_reg;
		burn = len / 2;
		if (tuned)
			return snapshot(1'b0);
		live_items++;
		if (!loaded) begin
			for (int i = 0; i < NGAINS; i++) begin
				gains_now[i] = start_gain_reg[i];
				gains_best[i] = start_gain_reg[i];
				steps[i] = start_step_reg[i];
			end
			score_best = PENALTY;
			tune_phase = TUNE_INIT;
			gain_idx = 0;
			clear_trial();
			loaded = 1'b1;
		end
		if (burn > BURN_IN_CAP_DEF)
			burn = BURN_IN_CAP_DEF;
		if (burn_cnt + 1 < burn) begin
			burn_cnt++;
			return snapshot(1'b0);
		end
		for (int i = WIN_DEPTH - 1; i > 0; i--)
			speed_win[i] = speed_win[i-1];
		speed_win[0] = mag;
		if (win_fill < WIN_DEPTH)
			win_fill++;
		est = PENALTY;
		ended = 1'b0;
		if (win_fill > WIN_MIN_FILL) begin
			wsum = 0;
			for (int i = 0; i < win_fill; i++)
				wsum += speed_win[i];
			if (wsum * SPD_LIM_NUM < longint'(win_fill) * SPD_LIM_DEN)
				ended = 1'b1;
		end
		if (!ended && (cte > CTE_LIMIT || cte < -CTE_LIMIT))
			ended = 1'b1;
		if (!ended) begin
			sq_sum += longint'(cte * cte);
			trial_cnt++;
			if (trial_cnt >= len) begin
				est = (sq_sum / trial_cnt) & 64'hFFFF_FFFF;
				ended = 1'b1;
			end
		end
		if (!ended)
			return snapshot(1'b0);
		gi = (gain_idx < NGAINS) ? gain_idx : 0;
		case (tune_phase)
			TUNE_PLUS: begin
				if (est < score_best) begin
					score_best = est;
					gains_best = gains_now;
					steps[gi] = scale_step(steps[gi], GROW_NUM);
					if (next_gain())
						return snapshot(1'b1);
					gains_now[gain_idx] = sat32(gains_now[gain_idx] + longint'(steps[gain_idx]));
				end else begin
					gains_now[gi] = sat32(gains_now[gi] - 2 * longint'(steps[gi]));
					tune_phase = TUNE_MINUS;
				end
			end
			TUNE_MINUS: begin
				if (est < score_best) begin
					score_best = est;
					gains_best = gains_now;
					steps[gi] = scale_step(steps[gi], GROW_NUM);
				end else begin
					gains_now[gi] = sat32(gains_now[gi] + longint'(steps[gi]));
					steps[gi] = scale_step(steps[gi], SHRINK_NUM);
				end
				if (next_gain())
					return snapshot(1'b1);
				gains_now[gain_idx] = sat32(gains_now[gain_idx] + longint'(steps[gain_idx]));
				tune_phase = TUNE_PLUS;
			end
			default: begin
				score_best = est;
				gain_idx = 0;
				gains_now[0] = sat32(gains_now[0] + longint'(steps[0]));
				tune_phase = TUNE_PLUS;
			end
		endcase
		clear_trial();
		return snapshot(1'b1);
	endfunction

	initial begin
		forever #4 clk = ~clk;
	end

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample.valid <= 1'b0;
			sample.data <= '0;
			send_gap <= 0;
		end else begin
			if (sample.valid && sample.ready) begin
				gains_q.push_back(tune_step(sample.data));
			end
			if (sample.valid && !sample.ready) begin
				// hold until transfer
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				sample.valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				send_gap <= $urandom_range(0, 18);
				sample.valid <= 1'b0;
			end else if (pend_q.size() > 0) begin
				sample.valid <= 1'b1;
				sample.data <= pend_q.pop_front();
			end else begin
				sample.valid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
			rcv_gap <= 0;
			hold_left <= 0;
			press_taken <= 1'b0;
		end else if (press_req && !press_taken) begin
			press_taken <= 1'b1;
			hold_left <= 600;
			result.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result.ready <= 1'b0;
		end else if (rcv_gap > 0) begin
			rcv_gap <= rcv_gap - 1;
			result.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			rcv_gap <= $urandom_range(0, 18);
			result.ready <= 1'b0;
		end else begin
			result.ready <= 1'b1;
		end
	end

	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			failed = 1'b1;
		end
	endtask

	always @(posedge clk) begin
		out_item_t want, got;
		if (arst_n && result.valid && result.ready) begin
			got = result.data;
			if (gains_q.size() == 0) begin
				$error("unexpected result transfer %h", got);
				failed = 1'b1;
			end else begin
				want = gains_q.pop_front();
				check_field("trial_gain_a", want.trial_gain_a, got.trial_gain_a);
				check_field("trial_gain_b", want.trial_gain_b, got.trial_gain_b);
				check_field("trial_gain_c", want.trial_gain_c, got.trial_gain_c);
				check_field("best_gain_a", want.best_gain_a, got.best_gain_a);
				check_field("best_gain_b", want.best_gain_b, got.best_gain_b);
				check_field("best_gain_c", want.best_gain_c, got.best_gain_c);
				check_field("best_score", want.best_score, got.best_score);
				check_field("restart_trial", want.restart_trial, got.restart_trial);
				check_field("tuning_done", want.tuning_done, got.tuning_done);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= '{index: idx, value: value};
		forever begin
			@(negedge clk);
			if (cfg.ready)
				break;
		end
		@(posedge clk);
		cfg.valid <= 1'b0;
		case (idx)
			REG_TRIAL_LENGTH: len_reg = value[LEN_W-1:0];
			REG_TOLERANCE:    tol_reg = value[STEP_W-1:0];
			REG_START_GAIN_A: start_gain_reg[0] = longint'(signed'(value));
			REG_START_GAIN_B: start_gain_reg[1] = longint'(signed'(value));
			REG_START_GAIN_C: start_gain_reg[2] = longint'(signed'(value));
			REG_START_STEP_A: start_step_reg[0] = value[STEP_W-1:0];
			REG_START_STEP_B: start_step_reg[1] = value[STEP_W-1:0];
			default:          start_step_reg[2] = value[STEP_W-1:0];
		endcase
	endtask

	task automatic wait_drained();
		while (pend_q.size() > 0 || gains_q.size() > 0 || sample.valid)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	function automatic in_item_t rand_sample();
		in_item_t it;
		int unsigned mode;
		mode = $urandom_range(0, 19);
		it.cte_sample = $urandom_range(0, 6656);
		if ($urandom_range(0, 1))
			it.cte_sample = -it.cte_sample;
		it.speed_sample = $urandom_range(600, 32767);
		if ($urandom_range(0, 1))
			it.speed_sample = -it.speed_sample;
		if (mode == 0)
			it.cte_sample = $urandom;
		else if (mode == 1)
			it.speed_sample = $urandom_range(0, 3);
		else if (mode == 2)
			it = $urandom;
		return it;
	endfunction

	task automatic push_batch(int n);
		repeat (n) pend_q.push_back(rand_sample());
	endtask

	initial begin
		logic signed [15:0] cte_edge [8] = '{16'sd0, 16'sd6656, -16'sd6656, 16'sd6657,
			-16'sd6657, 16'sh7FFF, 16'sh8000, -16'sd1};
		logic signed [15:0] spd_edge [8] = '{16'sh7FFF, 16'sh8000, -16'sd1, 16'sd0,
			16'sd600, -16'sd600, 16'sd1, 16'sd5};
		int n;
		cfg.valid = 1'b0;
		cfg.data = '0;
		reset_tuner();
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		write_reg(REG_TRIAL_LENGTH, 32'd4);
		write_reg(REG_TOLERANCE, 32'd50000);
		write_reg(REG_START_GAIN_A, 32'h7FFF_FFF0);
		write_reg(REG_START_GAIN_B, 32'h8000_0000);
		write_reg(REG_START_GAIN_C, $urandom);
		write_reg(REG_START_STEP_A, 32'd200000);
		write_reg(REG_START_STEP_B, 32'd1);
		write_reg(REG_START_STEP_C, 32'd0);
		// edges of both fields, then enough steady samples to end trials
		for (int i = 0; i < 8; i++)
			pend_q.push_back('{cte_sample: cte_edge[i], speed_sample: spd_edge[i]});
		for (int i = 0; i < 8; i++)
			pend_q.push_back('{cte_sample: cte_edge[i], speed_sample: 16'sd2000});
		repeat (6) pend_q.push_back('{cte_sample: 16'sd100, speed_sample: 16'sd0});
		wait_drained();
		// long trial, then shorten it so the count already passes the new length
		write_reg(REG_TRIAL_LENGTH, 32'd4095);
		press_req = 1'b1;
		push_batch(150);
		wait_drained();
		write_reg(REG_TRIAL_LENGTH, 32'd3);
		push_batch(30);
		wait_drained();
		// start step is latched after the first sample; tolerance applies at once
		write_reg(REG_TOLERANCE, 32'h7FFF_FFFF);
		write_reg(REG_START_STEP_A, 32'h7FFF_FFFF);
		write_reg(REG_TOLERANCE, 32'd0);
		n = 0;
		while (!tuned && live_items < 1000 && n < 60) begin
			case ($urandom_range(0, 5))
				0: write_reg(REG_TRIAL_LENGTH, 32'd0);
				1: write_reg(REG_TRIAL_LENGTH, 32'd1);
				default: write_reg(REG_TRIAL_LENGTH, $urandom_range(2, 12));
			endcase
			push_batch($urandom_range(20, 60));
			wait_drained();
			n++;
		end
		quiet = 1'b1;
		push_batch(40);
		wait_drained();
		if (failed)
			$display("testbench: FAIL");
		else
			$display("testbench: PASS");
		$finish;
	end

endmodule
